FILE: hdl/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types, sizes and codes of the chained hash table core.
// ----------------------------------------------------------------------------
package cht_pkg;

	localparam int MAX_BINS_LOG2 = 8;
	localparam int NUM_BINS      = 1 << MAX_BINS_LOG2;
	localparam int BIN_W         = MAX_BINS_LOG2;
	localparam int BIN_DEPTH     = 4;
	localparam int FILL_W        = $clog2(BIN_DEPTH + 1);
	localparam int ELEMENT_BITS  = 64;
	localparam int KEY_W         = 64;
	localparam int CFG_W         = 4;
	localparam int CNT_W         = 11;
	localparam int STATUS_W      = 2;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [KEY_W-1:0] HASH_ADD = 64'd18932479;
	localparam logic [31:0]      HASH_MUL = 32'd2654435761;

	localparam logic [CFG_W-1:0] BINS_LOG2_RESET = CFG_W'(MAX_BINS_LOG2);

	localparam logic CMD_PUT = 1'b0;
	localparam logic CMD_GET = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BIN_FULL  = 2'd2;

	typedef struct packed {
		logic                    cmd;
		logic [KEY_W-1:0]        key;
		logic [ELEMENT_BITS-1:0] value;
		logic [BIN_W-1:0]        bin;
	} cht_item_t;

	typedef struct packed {
		logic                    done;
		logic [STATUS_W-1:0]     status;
		logic [KEY_W-1:0]        read_value;
		logic [CNT_W-1:0]        stored_count;
	} cht_result_t;

endpackage

FILE: hdl/cht_front.sv
// ----------------------------------------------------------------------------
// cht_front
// Hash pipeline: offset add, split multiply, then bin index selection.
// ----------------------------------------------------------------------------
module cht_front
	import cht_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_cmd,
	input  logic [KEY_W-1:0]        in_key,
	input  logic [ELEMENT_BITS-1:0] in_value,
	input  logic [CFG_W-1:0]        bins_log2,
	output logic                    push,
	output cht_item_t               push_item
);

	localparam logic [CFG_W-1:0] LOG2_MAX = CFG_W'(MAX_BINS_LOG2);

	logic                    valid_s1;
	logic                    cmd_s1;
	logic [KEY_W-1:0]        key_s1;
	logic [ELEMENT_BITS-1:0] value_s1;
	logic [KEY_W-1:0]        sum_s1;

	logic                    valid_s2;
	logic                    cmd_s2;
	logic [KEY_W-1:0]        key_s2;
	logic [ELEMENT_BITS-1:0] value_s2;
	logic [31:0]             plo_hi_s2;
	logic [31:0]             phi_lo_s2;

	logic [63:0]             prod_lo;
	logic [63:0]             prod_hi;
	logic [31:0]             hash_hi;
	logic [BIN_W-1:0]        hash_top;
	logic [CFG_W-1:0]        log2_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1   <= in_cmd;
		key_s1   <= in_key;
		value_s1 <= in_value;
		sum_s1   <= in_key + HASH_ADD;
	end

	// The hash is kept mod 2^64, so the upper half of the sum only needs the
	// low 32 bits of its product.
	assign prod_lo = 64'(sum_s1[31:0]) * 64'(HASH_MUL);
	assign prod_hi = 64'(sum_s1[63:32]) * 64'(HASH_MUL);

	always_ff @(posedge clk) begin
		cmd_s2    <= cmd_s1;
		key_s2    <= key_s1;
		value_s2  <= value_s1;
		plo_hi_s2 <= prod_lo[63:32];
		phi_lo_s2 <= prod_hi[31:0];
	end

	assign hash_hi  = plo_hi_s2 + phi_lo_s2;
	assign hash_top = hash_hi[31 -: BIN_W];

	always_comb begin
		log2_eff = bins_log2;
		if (bins_log2 < CFG_W'(1))
			log2_eff = CFG_W'(1);
		if (bins_log2 > LOG2_MAX)
			log2_eff = LOG2_MAX;
	end

	assign push            = valid_s2;
	assign push_item.cmd   = cmd_s2;
	assign push_item.key   = key_s2;
	assign push_item.value = value_s2;
	assign push_item.bin   = hash_top >> (LOG2_MAX - log2_eff);

endmodule

FILE: hdl/cht_queue.sv
// ----------------------------------------------------------------------------
// cht_queue
// Small FIFO of hashed items between the front and back ends.
// ----------------------------------------------------------------------------
module cht_queue
	import cht_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cht_item_t push_item,
	input  logic      pop,
	output logic      empty,
	output cht_item_t head
);

	cht_item_t             slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;

	function automatic logic [QUEUE_AW-1:0] next_ptr(input logic [QUEUE_AW-1:0] p);
		logic [QUEUE_AW-1:0] n;
		n = p + QUEUE_AW'(1);
		if (p == QUEUE_AW'(QUEUE_DEPTH - 1))
			n = '0;
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + QUEUE_CW'(1);
			else if (pop && !push)
				count_q <= count_q - QUEUE_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_item;
	end

	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	overflow_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == QUEUE_CW'(QUEUE_DEPTH)) |-> !(push && !pop))
		else $error("cht_queue: push into a full queue");

	underflow_chk: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("cht_queue: pop from an empty queue");

endmodule

FILE: hdl/cht_back.sv
// ----------------------------------------------------------------------------
// cht_back
// Executes puts and gets against the bin fill memory and the slot memories.
// ----------------------------------------------------------------------------
module cht_back
	import cht_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  cht_item_t   head,
	output logic        pop,
	output cht_result_t result
);

	localparam logic STATE_IDLE = 1'b0;
	localparam logic STATE_EXEC = 1'b1;

	logic                    state_q;
	cht_item_t               item_q;

	logic [FILL_W-1:0]       fill_mem [NUM_BINS];
	logic [FILL_W-1:0]       fill_rd_q;
	logic [NUM_BINS-1:0]     fill_vld_q;
	logic [KEY_W-1:0]        key_rd_q [BIN_DEPTH];
	logic [ELEMENT_BITS-1:0] val_rd_q [BIN_DEPTH];

	logic [CNT_W-1:0]        total_q;
	logic                    done_q;
	logic [STATUS_W-1:0]     status_q;
	logic [KEY_W-1:0]        read_value_q;

	logic                    exec;
	logic [FILL_W-1:0]       fill;
	logic                    bin_full;
	logic                    do_store;
	logic [BIN_DEPTH-1:0]    slot_we;
	logic                    hit;
	logic [ELEMENT_BITS-1:0] hit_value;

	assign pop  = (state_q == STATE_IDLE) && !empty;
	assign exec = (state_q == STATE_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_IDLE;
		end else begin
			case (state_q)
				STATE_IDLE: if (pop) state_q <= STATE_EXEC;
				STATE_EXEC: state_q <= STATE_IDLE;
				default:    state_q <= STATE_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			item_q <= head;
	end

	// Bins that were never written read as empty through their valid bit.
	assign fill     = fill_vld_q[item_q.bin] ? fill_rd_q : '0;
	assign bin_full = (fill >= FILL_W'(BIN_DEPTH));
	assign do_store = exec && (item_q.cmd == CMD_PUT) && !bin_full;

	always_ff @(posedge clk) begin
		if (do_store)
			fill_mem[item_q.bin] <= fill + FILL_W'(1);
		if (pop)
			fill_rd_q <= fill_mem[head.bin];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_vld_q <= '0;
		end else if (do_store) begin
			fill_vld_q[item_q.bin] <= 1'b1;
		end
	end

	for (genvar s = 0; s < BIN_DEPTH; s++) begin : g_slot
		logic [KEY_W-1:0]        key_mem [NUM_BINS];
		logic [ELEMENT_BITS-1:0] val_mem [NUM_BINS];

		assign slot_we[s] = do_store && (fill == FILL_W'(s));

		always_ff @(posedge clk) begin
			if (slot_we[s]) begin
				key_mem[item_q.bin] <= item_q.key;
				val_mem[item_q.bin] <= item_q.value;
			end
			if (pop) begin
				key_rd_q[s] <= key_mem[head.bin];
				val_rd_q[s] <= val_mem[head.bin];
			end
		end
	end

	// The lowest matching slot wins, which is the oldest entry of the bin.
	always_comb begin
		hit       = 1'b0;
		hit_value = '0;
		for (int s = BIN_DEPTH - 1; s >= 0; s--) begin
			if ((FILL_W'(s) < fill) && (key_rd_q[s] == item_q.key)) begin
				hit       = 1'b1;
				hit_value = val_rd_q[s];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= exec;
			if (do_store)
				total_q <= total_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			read_value_q <= '0;
			if (item_q.cmd == CMD_PUT) begin
				status_q <= bin_full ? STATUS_BIN_FULL : STATUS_OK;
			end else begin
				status_q <= hit ? STATUS_OK : STATUS_NOT_FOUND;
				if (hit)
					read_value_q <= KEY_W'(hit_value);
			end
		end
	end

	assign result.done         = done_q;
	assign result.status       = status_q;
	assign result.read_value   = read_value_q;
	assign result.stored_count = total_q;

	count_step_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q != $past(total_q)) |-> (total_q == $past(total_q) + CNT_W'(1)))
		else $error("cht_back: stored count moved by other than one");

	count_bound_chk: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(NUM_BINS * BIN_DEPTH))
		else $error("cht_back: stored count exceeds capacity");

	done_after_exec_chk: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> done_q)
		else $error("cht_back: executed transaction produced no result");

	full_zero_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == STATUS_BIN_FULL || status_q == STATUS_NOT_FOUND))
			|-> (read_value_q == '0))
		else $error("cht_back: nonzero value on a failed transaction");

endmodule

FILE: hdl/chained_hash_table_core.sv
// ----------------------------------------------------------------------------
// chained_hash_table_core
// Key/value store with multiplicative hashing and fixed-depth bins.
//
// Channel   Direction  Handshake                Payload
// command   in         start high, busy low     cmd, key, value
// result    out        done strobe, one cycle   status, read_value, stored_count
// config    in         cfg_wr_en                cfg_wr_data (bins_log2)
//
// An accepted command passes the front-end stage registers s1 and s2, the
// queue and the back end; done is registered from the execute state. The back
// end handles each transaction in its idle state (bin memory read on pop),
// then its execute state (compare and write back), and pops no new transaction
// until it is back in idle. Busy rises once four transactions are between
// acceptance and the back end. Reset clears bin fills, the stored count and
// sets bins_log2 to 8; no clearing pass is needed. Results cannot be stalled.
// ----------------------------------------------------------------------------
module chained_hash_table_core
	import cht_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                cmd,
	input  logic [KEY_W-1:0]    key,
	input  logic [KEY_W-1:0]    value,
	input  logic                cfg_wr_en,
	input  logic [CFG_W-1:0]    cfg_wr_data,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [KEY_W-1:0]    read_value,
	output logic [CNT_W-1:0]    stored_count
);

	logic [CFG_W-1:0]    bins_log2_q;
	logic [QUEUE_CW-1:0] inflight_q;
	logic                accept;
	logic                push;
	cht_item_t           push_item;
	logic                pop;
	logic                empty;
	cht_item_t           head;
	cht_result_t         result;

	assign accept = start && !busy;
	assign busy   = (inflight_q == QUEUE_CW'(QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_log2_q <= BINS_LOG2_RESET;
		end else if (cfg_wr_en) begin
			bins_log2_q <= cfg_wr_data;
		end
	end

	// Counting from acceptance to pop keeps the queue from ever overflowing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (accept && !pop) begin
			inflight_q <= inflight_q + QUEUE_CW'(1);
		end else if (pop && !accept) begin
			inflight_q <= inflight_q - QUEUE_CW'(1);
		end
	end

	cht_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_cmd    (cmd),
		.in_key    (key),
		.in_value  (value[ELEMENT_BITS-1:0]),
		.bins_log2 (bins_log2_q),
		.push      (push),
		.push_item (push_item)
	);

	cht_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	cht_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

	assign done         = result.done;
	assign status       = result.status;
	assign read_value   = result.read_value;
	assign stored_count = result.stored_count;

endmodule

FILE: test/chained_hash_table_core_checker.sv
// ----------------------------------------------------------------------------
// chained_hash_table_core_checker
// Watches the command, result and config channels of the hash table core,
// keeps its own copy of the bins, and compares every result with the value
// predicted for the oldest outstanding transaction.
// ----------------------------------------------------------------------------
module chained_hash_table_core_checker
	import cht_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic                cmd,
	input  logic [KEY_W-1:0]    key,
	input  logic [KEY_W-1:0]    value,
	input  logic                cfg_wr_en,
	input  logic [CFG_W-1:0]    cfg_wr_data,
	input  logic                done,
	input  logic [STATUS_W-1:0] status,
	input  logic [KEY_W-1:0]    read_value,
	input  logic [CNT_W-1:0]    stored_count,
	output int                  error_count,
	output int                  pending_count
);

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    read_value;
		logic [CNT_W-1:0]    stored_count;
	} table_reply_t;

	logic [CFG_W-1:0]        bins_log2_m;
	int unsigned             bin_level [NUM_BINS];
	logic [KEY_W-1:0]        slot_key [NUM_BINS*BIN_DEPTH];
	logic [ELEMENT_BITS-1:0] slot_value [NUM_BINS*BIN_DEPTH];
	logic [CNT_W-1:0]        entries_held;
	table_reply_t            expected_replies [$];
	int                      errors_seen = 0;
	int                      outstanding = 0;

	assign error_count   = errors_seen;
	assign pending_count = outstanding;

	function automatic int unsigned bin_index(input logic [KEY_W-1:0] k);
		logic [63:0] h;
		int unsigned b;
		b = bins_log2_m;
		if (b < 1)
			b = 1;
		if (b > MAX_BINS_LOG2)
			b = MAX_BINS_LOG2;
		h = (k + HASH_ADD) * 64'(HASH_MUL);
		return int'(h >> (64 - b)) & (NUM_BINS - 1);
	endfunction

	// Updates the table copy and returns what the core should report.
	function automatic table_reply_t apply_table_op(input logic op,
			input logic [KEY_W-1:0] k, input logic [KEY_W-1:0] v);
		table_reply_t r;
		int unsigned  bin;
		int unsigned  base;
		int unsigned  level;
		logic         hit;
		bin   = bin_index(k);
		base  = bin * BIN_DEPTH;
		level = bin_level[bin];
		hit   = 1'b0;
		r.status     = STATUS_OK;
		r.read_value = '0;
		if (op == CMD_PUT) begin
			if (level >= BIN_DEPTH) begin
				r.status = STATUS_BIN_FULL;
			end else begin
				slot_key[base + level]   = k;
				slot_value[base + level] = v[ELEMENT_BITS-1:0];
				bin_level[bin]           = level + 1;
				entries_held             = entries_held + CNT_W'(1);
			end
		end else begin
			r.status = STATUS_NOT_FOUND;
			// Entries are scanned in insertion order, so the oldest duplicate wins.
			for (int i = 0; i < level && !hit; i++) begin
				if (slot_key[base + i] == k) begin
					hit          = 1'b1;
					r.read_value = KEY_W'(slot_value[base + i]);
					r.status     = STATUS_OK;
				end
			end
		end
		r.stored_count = entries_held;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			errors_seen++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		table_reply_t want;
		if (!arst_n) begin
			bins_log2_m  = BINS_LOG2_RESET;
			entries_held = '0;
			for (int i = 0; i < NUM_BINS; i++)
				bin_level[i] = 0;
			expected_replies.delete();
			outstanding = 0;
		end else begin
			if (start && !busy)
				expected_replies.push_back(apply_table_op(cmd, key, value));
			if (done) begin
				if (expected_replies.size() == 0) begin
					errors_seen++;
					$display("%0t: result with no transaction outstanding, status %0h",
						$time, status);
				end else begin
					want = expected_replies.pop_front();
					check_field("status", 64'(want.status), 64'(status));
					check_field("read_value", want.read_value, read_value);
					check_field("stored_count", 64'(want.stored_count), 64'(stored_count));
				end
			end
			if (cfg_wr_en)
				bins_log2_m = cfg_wr_data;
			outstanding = expected_replies.size();
		end
	end

endmodule

FILE: test/chained_hash_table_core_tb.sv
// ----------------------------------------------------------------------------
// chained_hash_table_core_tb
// Drives puts and gets into the hash table core under a series of bins_log2
// settings, with random idle bursts, and lets the checker judge each result.
// ----------------------------------------------------------------------------
module chained_hash_table_core_tb;
	import cht_pkg::*;

	localparam int NUM_PHASES   = 8;
	localparam int PHASE_ITEMS  = 223;
	localparam int POOL_SIZE    = 48;
	localparam int DRAIN_LIMIT  = 1000;
	localparam logic [KEY_W-1:0] WRAP_KEY = ~HASH_ADD + KEY_W'(1);

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                cmd = CMD_PUT;
	logic [KEY_W-1:0]    key = '0;
	logic [KEY_W-1:0]    value = '0;
	logic                cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]    cfg_wr_data = '0;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0]    read_value;
	logic [CNT_W-1:0]    stored_count;
	int                  error_count;
	int                  pending_count;

	logic [KEY_W-1:0]    key_pool [$];
	int                  puts_sent = 0;
	int                  gets_sent = 0;

	always #5 clk = ~clk;

	chained_hash_table_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.key          (key),
		.value        (value),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.done         (done),
		.status       (status),
		.read_value   (read_value),
		.stored_count (stored_count)
	);

	chained_hash_table_core_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.key           (key),
		.value         (value),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.done          (done),
		.status        (status),
		.read_value    (read_value),
		.stored_count  (stored_count),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic issue(input logic op, input logic [KEY_W-1:0] k,
			input logic [KEY_W-1:0] v);
		start <= 1'b1;
		cmd   <= op;
		key   <= k;
		value <= v;
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (op == CMD_PUT) begin
			puts_sent++;
			key_pool.push_back(k);
			if (key_pool.size() > POOL_SIZE)
				void'(key_pool.pop_front());
		end else begin
			gets_sent++;
		end
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Holds off new commands until every outstanding transaction has returned.
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending_count != 0);
	endtask

	task automatic write_bins_log2(input logic [CFG_W-1:0] setting);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= setting;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [KEY_W-1:0] pick_key(input int pool_weight);
		int r;
		r = $urandom_range(0, 99);
		if (key_pool.size() != 0 && r < pool_weight)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return '1;
			2:       return WRAP_KEY;
			default: return rand64();
		endcase
	endfunction

	initial begin
		logic [CFG_W-1:0] phase_setting [NUM_PHASES];
		logic             idling;
		logic             op;
		int               drained_at;
		phase_setting = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2, 4'd5, 4'd8};
		phase_setting[5] = CFG_W'($urandom_range(2, 7));
		drained_at = 0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset setting: empty table, extremes, duplicates,
		// a key whose offset wraps to zero, and one bin filled past its depth.
		issue(CMD_GET, '0, '0);
		issue(CMD_PUT, '0, '0);
		issue(CMD_PUT, '1, '1);
		issue(CMD_GET, '0, '0);
		issue(CMD_GET, '1, '0);
		issue(CMD_PUT, '0, 64'h5a5a_5a5a_5a5a_5a5a);
		issue(CMD_GET, '0, '1);
		issue(CMD_PUT, WRAP_KEY, 64'ha5a5_a5a5_a5a5_a5a5);
		issue(CMD_PUT, WRAP_KEY, 64'd1);
		issue(CMD_PUT, WRAP_KEY, 64'd2);
		issue(CMD_PUT, WRAP_KEY, 64'd3);
		issue(CMD_PUT, WRAP_KEY, 64'd4);
		issue(CMD_GET, WRAP_KEY, '0);
		issue(CMD_GET, 64'd1, '0);
		issue(CMD_PUT, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
		issue(CMD_GET, 64'h8000_0000_0000_0000, '0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_bins_log2(phase_setting[p]);
			idling = 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 30 == 0)
					idling = (p != NUM_PHASES - 1) && ($urandom_range(0, 1) == 1);
				// Well-formed traffic: gets mostly look up keys that were put.
				op = ($urandom_range(0, 99) < 45) ? CMD_PUT : CMD_GET;
				if (op == CMD_PUT)
					issue(CMD_PUT, pick_key(25), rand64());
				else
					issue(CMD_GET, pick_key(70), rand64());
				if (p == 2 && n == PHASE_ITEMS / 2) begin
					drain();
					drained_at = n;
				end else if (idling && $urandom_range(0, 3) == 0) begin
					pause($urandom_range(1, 12));
				end
			end
		end

		start <= 1'b0;
		for (int c = 0; c < DRAIN_LIMIT && pending_count != 0; c++)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (pending_count != 0)
			$display("%0t: %0d transactions never returned a result", $time, pending_count);

		$display("Sent %0d puts and %0d gets under %0d bins_log2 settings (0 through 15),",
			puts_sent, gets_sent, NUM_PHASES + 1);
		$display("including full bins, misses, duplicate keys and a mid-run drain at item %0d.",
			drained_at);
		if (error_count == 0 && pending_count == 0)
			$display("chained_hash_table_core_tb: done, clean");
		else
			$display("chained_hash_table_core_tb: done, errors");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("%0t: run did not finish in time", $time);
		$display("chained_hash_table_core_tb: done, errors");
		$finish;
	end

endmodule
